>>> rtl/tiled_pattern_texel_sampler_macros.svh
// Assertion macros shared by the sampler's checker.
// Needs no other file; included by name where assertions are written.
`ifndef TILED_PATTERN_TEXEL_SAMPLER_MACROS_SVH
`define TILED_PATTERN_TEXEL_SAMPLER_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define TPTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpts: same-cycle check failed");

// Next-cycle implication, off while reset is asserted
`define TPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpts: next-cycle check failed");

// Next-cycle implication that also holds through reset
`define TPTS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tpts: reset check failed");

`endif

>>> rtl/tpts_pkg.sv
// Shared types, widths and helpers of the tiled pattern texel sampler.
// No dependencies; used by tpts_front, tpts_back, tpts_outq, the top level and the testbench.
`default_nettype none

package tpts_pkg;

    // Default sizes handed to the top level parameters
    localparam int TILE_W_MAX_DEF  = 128;
    localparam int TILE_H_MAX_DEF  = 128;
    localparam int FRAC_BITS_DEF   = 16;

    // Field and datapath widths
    localparam int HALF_W    = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_W     = 12;
    localparam int TEX_IDX_W = 7;
    localparam int RGBA_W    = 32;
    localparam int DIM_W     = 8;
    localparam int PROD1_W   = HALF_W + PIX_W + 1;
    localparam int USUM_W    = PROD1_W + 2;
    localparam int TIDX_W    = 24;
    localparam int PROD2_W   = TIDX_W + HALF_W;
    localparam int SSUM_W    = PROD2_W + 4;

    // Queue depths
    localparam int FRONT_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int LEVEL_W     = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_U_COEFFS  = 3'd0,
        REG_TILE_V_COEFFS  = 3'd1,
        REG_TILE_UV_ORIGIN = 3'd2,
        REG_STEP_ACROSS    = 3'd3,
        REG_STEP_DOWN      = 3'd4,
        REG_SOURCE_ORIGIN  = 3'd5,
        REG_SOURCE_WIDTH   = 3'd6,
        REG_SOURCE_HEIGHT  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [CFG_W-1:0] tile_u_coeffs;
        logic [CFG_W-1:0] tile_v_coeffs;
        logic [CFG_W-1:0] tile_uv_origin;
        logic [CFG_W-1:0] step_across;
        logic [CFG_W-1:0] step_down;
        logic [CFG_W-1:0] source_origin;
        logic [DIM_W-1:0] source_width;
        logic [DIM_W-1:0] source_height;
    } t_cfg;

    // One classified item on its way from the front to the back
    typedef struct packed {
        t_opcode               op;
        logic                  load_ok;
        logic [PIX_W-1:0]      px;
        logic [PIX_W-1:0]      py;
        logic [TEX_IDX_W-1:0]  col;
        logic [TEX_IDX_W-1:0]  row;
        logic [RGBA_W-1:0]     rgba;
    } t_work_item;

    typedef struct packed {
        logic [RGBA_W-1:0] rgba;
        logic              in_bounds;
    } t_result;

    // Column / x half of a packed register
    function automatic logic signed [HALF_W-1:0] half_lo(input logic [CFG_W-1:0] w);
        half_lo = $signed(w[HALF_W-1:0]);
    endfunction

    // Row / y half of a packed register
    function automatic logic signed [HALF_W-1:0] half_hi(input logic [CFG_W-1:0] w);
        half_hi = $signed(w[CFG_W-1:HALF_W]);
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the pattern texel store.
`default_nettype none

module tpts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic                                      i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/tpts_front.sv
// Front end: accepts input items, classifies loads and samples, queues them.
// Depends on tpts_pkg.
`default_nettype none

module tpts_front #(
    parameter int TILE_W_MAX = tpts_pkg::TILE_W_MAX_DEF,
    parameter int TILE_H_MAX = tpts_pkg::TILE_H_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic                            i_opcode,
    input  wire logic [tpts_pkg::PIX_W-1:0]      i_pixel_x,
    input  wire logic [tpts_pkg::PIX_W-1:0]      i_pixel_y,
    input  wire logic [tpts_pkg::TEX_IDX_W-1:0]  i_texel_col,
    input  wire logic [tpts_pkg::TEX_IDX_W-1:0]  i_texel_row,
    input  wire logic [tpts_pkg::RGBA_W-1:0]     i_texel_rgba,
    input  wire logic                            i_take,
    output logic                                 o_valid,
    output tpts_pkg::t_work_item                 o_item
);

    localparam int Depth = tpts_pkg::FRONT_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    tpts_pkg::t_work_item r_q [Depth];
    tpts_pkg::t_work_item n_entry;
    logic [PtrW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic                 s_wr;

    // Classify the incoming item; loads outside the store are marked dead
    always_comb begin
        n_entry         = '0;
        n_entry.op      = tpts_pkg::t_opcode'(i_opcode);
        n_entry.load_ok = (32'(i_texel_col) < 32'(TILE_W_MAX)) &&
                          (32'(i_texel_row) < 32'(TILE_H_MAX));
        n_entry.px      = i_pixel_x;
        n_entry.py      = i_pixel_y;
        n_entry.col     = i_texel_col;
        n_entry.row     = i_texel_row;
        n_entry.rgba    = i_texel_rgba;
    end

    assign o_full  = (r_cnt == CntW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd_ptr];
    assign s_wr    = i_push && !o_full;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (s_wr) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_take) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (s_wr && !i_take) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!s_wr && i_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_q[r_wr_ptr] <= n_entry;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpts_back.sv
// Back end: six-stage sampling pipeline with the texel store and load writes.
// Depends on tpts_pkg and tpts_ram.
`default_nettype none

module tpts_back #(
    parameter int TILE_W_MAX = tpts_pkg::TILE_W_MAX_DEF,
    parameter int TILE_H_MAX = tpts_pkg::TILE_H_MAX_DEF,
    parameter int FRAC_BITS  = tpts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tpts_pkg::t_cfg                i_cfg,
    input  wire logic                          i_valid,
    input  wire tpts_pkg::t_work_item          i_item,
    output logic                               o_take,
    input  wire logic [tpts_pkg::LEVEL_W-1:0]  i_level,
    output logic                               o_res_valid,
    output tpts_pkg::t_result                  o_res
);

    localparam int Depth   = TILE_W_MAX * TILE_H_MAX;
    localparam int AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int OccW    = tpts_pkg::LEVEL_W + 1;
    localparam int P1W     = tpts_pkg::PROD1_W;
    localparam int UW      = tpts_pkg::USUM_W;
    localparam int TW      = tpts_pkg::TIDX_W;
    localparam int P2W     = tpts_pkg::PROD2_W;
    localparam int SW      = tpts_pkg::SSUM_W;
    localparam int DW      = tpts_pkg::DIM_W;
    localparam logic signed [UW-1:0] IdxMax  = UW'(2 ** (TW - 1) - 1);
    localparam logic signed [UW-1:0] IdxMin  = -IdxMax - UW'(1);
    localparam logic signed [SW-1:0] FracOne = SW'(1) << FRAC_BITS;

    // Stage registers
    logic                        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic                        r_s5_valid, r_s6_valid;
    tpts_pkg::t_work_item        r_s1_item, r_s2_item, r_s3_item, r_s4_item;
    logic signed [P1W-1:0]       r_s1_pux, r_s1_puy, r_s1_pvx, r_s1_pvy;
    logic signed [TW-1:0]        r_s2_gu, r_s2_gv;
    logic signed [P2W-1:0]       r_s3_pax, r_s3_pdx, r_s3_pay, r_s3_pdy;
    logic signed [SW-1:0]        r_s4_sx, r_s4_sy;
    logic                        r_s5_sample, r_s5_we, r_s5_inb;
    logic [AddrW-1:0]            r_s5_addr;
    logic [tpts_pkg::RGBA_W-1:0] r_s5_rgba;
    logic                        r_s6_inb;

    // Next-value signals
    logic signed [P1W-1:0]       n_s1_pux, n_s1_puy, n_s1_pvx, n_s1_pvy;
    logic signed [UW-1:0]        n_s2_u, n_s2_v, n_s2_fu, n_s2_fv;
    logic signed [TW-1:0]        n_s2_gu, n_s2_gv;
    logic signed [P2W-1:0]       n_s3_pax, n_s3_pdx, n_s3_pay, n_s3_pdy;
    logic signed [SW-1:0]        n_s4_sx, n_s4_sy;
    logic signed [SW-1:0]        n_s5_qx, n_s5_qy;
    logic [DW-1:0]               n_s5_w, n_s5_h, n_s5_xi, n_s5_yi, n_s5_col, n_s5_row;
    logic                        n_s5_xok, n_s5_yok;
    logic [AddrW-1:0]            n_s5_addr;
    logic [OccW-1:0]             n_occ;
    logic [tpts_pkg::RGBA_W-1:0] s_ram_q;

    // Take an item only while the result queue has room for everything in flight
    always_comb begin
        n_occ  = OccW'(i_level) + OccW'($countones({r_s1_valid, r_s2_valid, r_s3_valid,
                                                     r_s4_valid, r_s5_valid, r_s6_valid}));
        o_take = i_valid && (n_occ < OccW'(tpts_pkg::OUT_DEPTH));
    end

    // Stage 1: tile coordinate products
    always_comb begin
        n_s1_pux = tpts_pkg::half_lo(i_cfg.tile_u_coeffs) * $signed({1'b0, i_item.px});
        n_s1_puy = tpts_pkg::half_hi(i_cfg.tile_u_coeffs) * $signed({1'b0, i_item.py});
        n_s1_pvx = tpts_pkg::half_lo(i_cfg.tile_v_coeffs) * $signed({1'b0, i_item.px});
        n_s1_pvy = tpts_pkg::half_hi(i_cfg.tile_v_coeffs) * $signed({1'b0, i_item.py});
    end

    // Stage 2: sum, floor and saturate the tile indices
    always_comb begin
        n_s2_u  = UW'(r_s1_pux) + UW'(r_s1_puy) + UW'(tpts_pkg::half_lo(i_cfg.tile_uv_origin));
        n_s2_v  = UW'(r_s1_pvx) + UW'(r_s1_pvy) + UW'(tpts_pkg::half_hi(i_cfg.tile_uv_origin));
        n_s2_fu = n_s2_u >>> FRAC_BITS;
        n_s2_fv = n_s2_v >>> FRAC_BITS;
        if (n_s2_fu > IdxMax) begin
            n_s2_gu = TW'(IdxMax);
        end else if (n_s2_fu < IdxMin) begin
            n_s2_gu = TW'(IdxMin);
        end else begin
            n_s2_gu = TW'(n_s2_fu);
        end
        if (n_s2_fv > IdxMax) begin
            n_s2_gv = TW'(IdxMax);
        end else if (n_s2_fv < IdxMin) begin
            n_s2_gv = TW'(IdxMin);
        end else begin
            n_s2_gv = TW'(n_s2_fv);
        end
    end

    // Stage 3: tile step products
    always_comb begin
        n_s3_pax = r_s2_gu * tpts_pkg::half_lo(i_cfg.step_across);
        n_s3_pdx = r_s2_gv * tpts_pkg::half_lo(i_cfg.step_down);
        n_s3_pay = r_s2_gu * tpts_pkg::half_hi(i_cfg.step_across);
        n_s3_pdy = r_s2_gv * tpts_pkg::half_hi(i_cfg.step_down);
    end

    // Stage 4: source position in fixed point
    always_comb begin
        n_s4_sx = $signed(SW'(r_s3_item.px) << FRAC_BITS) - SW'(r_s3_pax) - SW'(r_s3_pdx)
                  + SW'(tpts_pkg::half_lo(i_cfg.source_origin));
        n_s4_sy = $signed(SW'(r_s3_item.py) << FRAC_BITS) - SW'(r_s3_pay) - SW'(r_s3_pdy)
                  + SW'(tpts_pkg::half_hi(i_cfg.source_origin));
    end

    // Stage 5: truncate toward zero, bounds test, store address
    always_comb begin
        n_s5_w = (32'(i_cfg.source_width) > 32'(TILE_W_MAX)) ? DW'(TILE_W_MAX)
                                                               : i_cfg.source_width;
        n_s5_h = (32'(i_cfg.source_height) > 32'(TILE_H_MAX)) ? DW'(TILE_H_MAX)
                                                                : i_cfg.source_height;
        n_s5_qx = r_s4_sx >>> FRAC_BITS;
        n_s5_qy = r_s4_sy >>> FRAC_BITS;
        // A negative fraction above minus one truncates to column zero
        if (r_s4_sx < 0) begin
            n_s5_xok = (r_s4_sx > -FracOne) && (n_s5_w != '0);
            n_s5_xi  = '0;
        end else begin
            n_s5_xok = $unsigned(n_s5_qx) < SW'(n_s5_w);
            n_s5_xi  = n_s5_qx[DW-1:0];
        end
        if (r_s4_sy < 0) begin
            n_s5_yok = (r_s4_sy > -FracOne) && (n_s5_h != '0);
            n_s5_yi  = '0;
        end else begin
            n_s5_yok = $unsigned(n_s5_qy) < SW'(n_s5_h);
            n_s5_yi  = n_s5_qy[DW-1:0];
        end
        // Loads address the store by their own column and row
        if (r_s4_item.op == tpts_pkg::OP_LOAD) begin
            n_s5_col = DW'(r_s4_item.col);
            n_s5_row = DW'(r_s4_item.row);
        end else begin
            n_s5_col = n_s5_xi;
            n_s5_row = n_s5_yi;
        end
        n_s5_addr = AddrW'(n_s5_row) * AddrW'(TILE_W_MAX) + AddrW'(n_s5_col);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_take;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid && r_s5_sample;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_s1_item   <= i_item;
        r_s1_pux    <= n_s1_pux;
        r_s1_puy    <= n_s1_puy;
        r_s1_pvx    <= n_s1_pvx;
        r_s1_pvy    <= n_s1_pvy;
        r_s2_item   <= r_s1_item;
        r_s2_gu     <= n_s2_gu;
        r_s2_gv     <= n_s2_gv;
        r_s3_item   <= r_s2_item;
        r_s3_pax    <= n_s3_pax;
        r_s3_pdx    <= n_s3_pdx;
        r_s3_pay    <= n_s3_pay;
        r_s3_pdy    <= n_s3_pdy;
        r_s4_item   <= r_s3_item;
        r_s4_sx     <= n_s4_sx;
        r_s4_sy     <= n_s4_sy;
        r_s5_sample <= (r_s4_item.op == tpts_pkg::OP_SAMPLE);
        r_s5_we     <= (r_s4_item.op == tpts_pkg::OP_LOAD) && r_s4_item.load_ok;
        r_s5_inb    <= n_s5_xok && n_s5_yok;
        r_s5_addr   <= n_s5_addr;
        r_s5_rgba   <= r_s4_item.rgba;
        r_s6_inb    <= r_s5_inb;
    end

    // Texel store: loads write and samples read at the same stage, in order
    tpts_ram #(
        .WIDTH (tpts_pkg::RGBA_W),
        .DEPTH (Depth)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_s5_valid && r_s5_we),
        .i_waddr (r_s5_addr),
        .i_wdata (r_s5_rgba),
        .i_re    (r_s5_valid && r_s5_sample && r_s5_inb),
        .i_raddr (r_s5_addr),
        .o_rdata (s_ram_q)
    );

    // Stage 6: drop colour of out-of-range texels
    assign o_res_valid     = r_s6_valid;
    assign o_res.rgba      = r_s6_inb ? s_ram_q : '0;
    assign o_res.in_bounds = r_s6_inb;

endmodule

`default_nettype wire

>>> rtl/tpts_outq.sv
// Result queue between the sampling pipeline and the result ports.
// Depends on tpts_pkg.
`default_nettype none

module tpts_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire tpts_pkg::t_result             i_res,
    output logic [tpts_pkg::LEVEL_W-1:0]       o_level,
    input  wire logic                          i_pop,
    output logic                               o_empty,
    output tpts_pkg::t_result                  o_res
);

    localparam int Depth = tpts_pkg::OUT_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = tpts_pkg::LEVEL_W;

    tpts_pkg::t_result r_q [Depth];
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic              s_rd;

    assign o_empty = (r_cnt == '0);
    assign o_level = r_cnt;
    assign o_res   = r_q[r_rd_ptr];
    assign s_rd    = i_pop && !o_empty;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (s_rd) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !s_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && s_rd) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tiled_pattern_texel_sampler.sv
// Top level of the tiled pattern texel sampler: configuration registers and glue.
// Depends on tpts_pkg, tpts_front, tpts_back, tpts_outq.
//
// Load items write one RGBA texel into a TILE_W_MAX x TILE_H_MAX store; sample
// items map an output pixel through the tile-space affine, floor to tile
// indices, step back into the pattern and return the stored texel, or zero
// with in_bounds low when the texel lies outside source_width x source_height.
// The block takes one item per clock, loads and samples mixed in any order,
// and keeps their order: a sample sees every load accepted before it. A
// sample's result reaches the result ports through the four-entry input
// queue, the six-stage pipeline whose fifth stage owns the store's write and
// read ports, and then the result queue. Throughput is one item
// per cycle as long as results are popped; the eight-entry result queue holds
// back the pipeline only when results pile up. The store has no reset and
// needs no clearing: sampling a texel never loaded returns an undefined colour.
// Configuration writes take effect at once and belong to idle periods.
`default_nettype none

module tiled_pattern_texel_sampler #(
    parameter int TILE_W_MAX = tpts_pkg::TILE_W_MAX_DEF,
    parameter int TILE_H_MAX = tpts_pkg::TILE_H_MAX_DEF,
    parameter int FRAC_BITS  = tpts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            i_opcode,
    input  wire logic [tpts_pkg::PIX_W-1:0]      i_pixel_x,
    input  wire logic [tpts_pkg::PIX_W-1:0]      i_pixel_y,
    input  wire logic [tpts_pkg::TEX_IDX_W-1:0]  i_texel_col,
    input  wire logic [tpts_pkg::TEX_IDX_W-1:0]  i_texel_row,
    input  wire logic [tpts_pkg::RGBA_W-1:0]     i_texel_rgba,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic      [tpts_pkg::RGBA_W-1:0]     o_pixel_rgba,
    output logic                                 o_in_bounds,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tpts_pkg::CFG_W-1:0]      i_cfg_data
);

    tpts_pkg::t_cfg                r_cfg, n_cfg;
    logic                          s_front_valid;
    tpts_pkg::t_work_item          s_front_item;
    logic                          s_take;
    logic [tpts_pkg::LEVEL_W-1:0]  s_level;
    logic                          s_res_valid;
    tpts_pkg::t_result             s_res;
    tpts_pkg::t_result             s_out;

    // Configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (tpts_pkg::t_cfg_reg'(i_cfg_index))
                tpts_pkg::REG_TILE_U_COEFFS:  n_cfg.tile_u_coeffs  = i_cfg_data;
                tpts_pkg::REG_TILE_V_COEFFS:  n_cfg.tile_v_coeffs  = i_cfg_data;
                tpts_pkg::REG_TILE_UV_ORIGIN: n_cfg.tile_uv_origin = i_cfg_data;
                tpts_pkg::REG_STEP_ACROSS:    n_cfg.step_across    = i_cfg_data;
                tpts_pkg::REG_STEP_DOWN:      n_cfg.step_down      = i_cfg_data;
                tpts_pkg::REG_SOURCE_ORIGIN:  n_cfg.source_origin  = i_cfg_data;
                tpts_pkg::REG_SOURCE_WIDTH:
                    n_cfg.source_width  = i_cfg_data[tpts_pkg::DIM_W-1:0];
                tpts_pkg::REG_SOURCE_HEIGHT:
                    n_cfg.source_height = i_cfg_data[tpts_pkg::DIM_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tpts_front #(
        .TILE_W_MAX (TILE_W_MAX),
        .TILE_H_MAX (TILE_H_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_opcode     (i_opcode),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_texel_col  (i_texel_col),
        .i_texel_row  (i_texel_row),
        .i_texel_rgba (i_texel_rgba),
        .i_take       (s_take),
        .o_valid      (s_front_valid),
        .o_item       (s_front_item)
    );

    tpts_back #(
        .TILE_W_MAX (TILE_W_MAX),
        .TILE_H_MAX (TILE_H_MAX),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (s_front_valid),
        .i_item      (s_front_item),
        .o_take      (s_take),
        .i_level     (s_level),
        .o_res_valid (s_res_valid),
        .o_res       (s_res)
    );

    tpts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_valid),
        .i_res   (s_res),
        .o_level (s_level),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (s_out)
    );

    assign o_pixel_rgba = s_out.rgba;
    assign o_in_bounds  = s_out.in_bounds;

endmodule

`default_nettype wire

>>> rtl/tpts_checker.sv
// Port-level checker for the tiled pattern texel sampler, bound to the top level.
// Depends on tiled_pattern_texel_sampler_macros.svh.
`default_nettype none

`include "tiled_pattern_texel_sampler_macros.svh"

module tpts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_pixel_rgba,
    input wire logic        o_in_bounds
);

    // Transparent results carry no stale colour
    `TPTS_ASSERT_NOW(a_oob_black, i_clk, i_rst_n, !empty && !o_in_bounds, o_pixel_rgba == '0)

    // Hold an unaccepted result
    `TPTS_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_pixel_rgba) && $stable(o_in_bounds))

    // Leave reset with both queues drained
    `TPTS_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, empty && !full)

endmodule

bind tiled_pattern_texel_sampler tpts_checker u_tpts_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of tiled_pattern_texel_sampler: texel loads and pixel samples
// checked against an in-bench tile-mapping predictor. Depends on tpts_pkg and the RTL.

module tb_top;

    localparam int FRAC         = tpts_pkg::FRAC_BITS_DEF;
    localparam int ONE          = 1 << FRAC;
    localparam int TILE_W       = tpts_pkg::TILE_W_MAX_DEF;
    localparam int TILE_H       = tpts_pkg::TILE_H_MAX_DEF;
    localparam int TEX_WORDS    = TILE_W * TILE_H;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_ITEMS  = 96;
    localparam int CFG_W        = tpts_pkg::CFG_W;
    localparam int CFG_IDX_W    = tpts_pkg::CFG_IDX_W;
    localparam int DIM_W        = tpts_pkg::DIM_W;
    localparam int PIX_W        = tpts_pkg::PIX_W;
    localparam int TEX_IDX_W    = tpts_pkg::TEX_IDX_W;
    localparam int RGBA_W       = tpts_pkg::RGBA_W;

    typedef tpts_pkg::t_cfg     t_cfg;
    typedef tpts_pkg::t_cfg_reg t_cfg_reg;
    typedef tpts_pkg::t_result  t_result;
    typedef tpts_pkg::t_opcode  t_opcode;

    // Expected pixels and the predictor state behind them
    class pixel_scoreboard;
        t_cfg      regs;
        bit [31:0] texels [TEX_WORDS];
        bit        written [TEX_WORDS];
        t_result   expected_pixels [$];
        int        errors;

        function new();
            regs   = '0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_reg r, logic [CFG_W-1:0] d);
            case (r)
                tpts_pkg::REG_TILE_U_COEFFS:  regs.tile_u_coeffs  = d;
                tpts_pkg::REG_TILE_V_COEFFS:  regs.tile_v_coeffs  = d;
                tpts_pkg::REG_TILE_UV_ORIGIN: regs.tile_uv_origin = d;
                tpts_pkg::REG_STEP_ACROSS:    regs.step_across    = d;
                tpts_pkg::REG_STEP_DOWN:      regs.step_down      = d;
                tpts_pkg::REG_SOURCE_ORIGIN:  regs.source_origin  = d;
                tpts_pkg::REG_SOURCE_WIDTH:   regs.source_width   = d[DIM_W-1:0];
                default:                      regs.source_height  = d[DIM_W-1:0];
            endcase
        endfunction

        function longint col_part(logic [CFG_W-1:0] w);
            return longint'($signed(w[31:0]));
        endfunction

        function longint row_part(logic [CFG_W-1:0] w);
            return longint'($signed(w[63:32]));
        endfunction

        // Floor to a tile index, saturated to 24 signed bits
        function longint tile_floor(longint v);
            longint r;
            r = v >>> FRAC;
            if (r > 64'sd8388607) r = 64'sd8388607;
            if (r < -64'sd8388608) r = -64'sd8388608;
            return r;
        endfunction

        function longint toward_zero(longint v);
            return (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
        endfunction

        // Map an output pixel to its texel address and bounds flag
        function void map_to_texel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                   output int addr, output bit inb);
            longint x, y, u, v, gu, gv, tx, ty, wd, ht;
            x  = px;
            y  = py;
            u  = col_part(regs.tile_u_coeffs) * x + row_part(regs.tile_u_coeffs) * y
                 + col_part(regs.tile_uv_origin);
            v  = col_part(regs.tile_v_coeffs) * x + row_part(regs.tile_v_coeffs) * y
                 + row_part(regs.tile_uv_origin);
            gu = tile_floor(u);
            gv = tile_floor(v);
            tx = toward_zero(x * ONE - gu * col_part(regs.step_across)
                             - gv * col_part(regs.step_down) + col_part(regs.source_origin));
            ty = toward_zero(y * ONE - gu * row_part(regs.step_across)
                             - gv * row_part(regs.step_down) + row_part(regs.source_origin));
            wd = regs.source_width;
            ht = regs.source_height;
            if (wd > TILE_W) wd = TILE_W;
            if (ht > TILE_H) ht = TILE_H;
            inb  = (tx >= 0) && (tx < wd) && (ty >= 0) && (ty < ht);
            addr = inb ? int'(ty) * TILE_W + int'(tx) : 0;
        endfunction

        // True when a sample would hit a texel that holds nothing yet
        function bit hits_blank(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, output int addr);
            bit inb;
            map_to_texel(px, py, addr, inb);
            return inb && !written[addr];
        endfunction

        function void note_item(t_opcode op, logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                logic [TEX_IDX_W-1:0] col, logic [TEX_IDX_W-1:0] row,
                                logic [RGBA_W-1:0] rgba);
            int      addr;
            bit      inb;
            t_result r;
            if (op == tpts_pkg::OP_LOAD) begin
                addr          = int'(row) * TILE_W + int'(col);
                texels[addr]  = rgba;
                written[addr] = 1'b1;
            end else begin
                map_to_texel(px, py, addr, inb);
                r.rgba      = inb ? texels[addr] : '0;
                r.in_bounds = inb;
                expected_pixels.push_back(r);
            end
        endfunction

        function void check_pixel(logic [RGBA_W-1:0] rgba, logic inb);
            t_result r;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: pixel_rgba %h in_bounds %b", rgba, inb);
                errors++;
                return;
            end
            r = expected_pixels.pop_front();
            if (rgba !== r.rgba) begin
                $error("pixel_rgba: expected %h, got %h", r.rgba, rgba);
                errors++;
            end
            if (inb !== r.in_bounds) begin
                $error("in_bounds: expected %b, got %b", r.in_bounds, inb);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic                  i_opcode;
    logic [PIX_W-1:0]      i_pixel_x;
    logic [PIX_W-1:0]      i_pixel_y;
    logic [TEX_IDX_W-1:0]  i_texel_col;
    logic [TEX_IDX_W-1:0]  i_texel_row;
    logic [RGBA_W-1:0]     i_texel_rgba;
    logic                  empty;
    logic                  pop;
    logic [RGBA_W-1:0]     o_pixel_rgba;
    logic                  o_in_bounds;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    pixel_scoreboard sb = new();
    bit              calm = 1'b0;
    int              sent = 0;
    int              cycle_count = 0;

    tiled_pattern_texel_sampler u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_opcode     (i_opcode),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_texel_col  (i_texel_col),
        .i_texel_row  (i_texel_row),
        .i_texel_rgba (i_texel_rgba),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_rgba (o_pixel_rgba),
        .o_in_bounds  (o_in_bounds),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Pop results with random stalls and check every transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) sb.check_pixel(o_pixel_rgba, o_in_bounds);
            pop <= calm || ($urandom_range(99) >= 7);
        end
    end

    function automatic logic [CFG_W-1:0] pack_fix(int lo, int hi);
        return {hi, lo};
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic logic [31:0] corner_half();
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] corner_dim();
        case ($urandom_range(2))
            0:       return 8'd0;
            1:       return 8'd128;
            default: return 8'd255;
        endcase
    endfunction

    // Regular repeat tiling with occasional shear and sub-pixel offsets
    function automatic t_cfg make_tiled();
        t_cfg c;
        int   tw, th;
        tw = $urandom_range(1, 64);
        th = $urandom_range(1, 64);
        c.tile_u_coeffs  = pack_fix(ONE / tw, ($urandom_range(3) == 0) ? jitter(ONE / 16) : 0);
        c.tile_v_coeffs  = pack_fix(($urandom_range(3) == 0) ? jitter(ONE / 16) : 0, ONE / th);
        c.tile_uv_origin = pack_fix(jitter(ONE), jitter(ONE));
        c.step_across    = pack_fix(tw * ONE, ($urandom_range(3) == 0) ? jitter(ONE) : 0);
        c.step_down      = pack_fix(($urandom_range(3) == 0) ? jitter(ONE) : 0, th * ONE);
        c.source_origin  = pack_fix(jitter(2 * ONE), jitter(2 * ONE));
        c.source_width   = ($urandom_range(4) == 0) ? 8'($urandom_range(129, 255))
                                                    : 8'(tw + $urandom_range(4));
        c.source_height  = ($urandom_range(4) == 0) ? 8'($urandom_range(129, 255))
                                                    : 8'(th + $urandom_range(4));
        return c;
    endfunction

    function automatic t_cfg make_noise();
        t_cfg c;
        c.tile_u_coeffs  = {$urandom, $urandom};
        c.tile_v_coeffs  = {$urandom, $urandom};
        c.tile_uv_origin = {$urandom, $urandom};
        c.step_across    = {$urandom, $urandom};
        c.step_down      = {$urandom, $urandom};
        c.source_origin  = {$urandom, $urandom};
        c.source_width   = 8'($urandom);
        c.source_height  = 8'($urandom);
        return c;
    endfunction

    function automatic t_cfg make_extreme();
        t_cfg c;
        c.tile_u_coeffs  = {corner_half(), corner_half()};
        c.tile_v_coeffs  = {corner_half(), corner_half()};
        c.tile_uv_origin = {corner_half(), corner_half()};
        c.step_across    = {corner_half(), corner_half()};
        c.step_down      = {corner_half(), corner_half()};
        c.source_origin  = {corner_half(), corner_half()};
        c.source_width   = corner_dim();
        c.source_height  = corner_dim();
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] reg_value(t_cfg c, t_cfg_reg r);
        case (r)
            tpts_pkg::REG_TILE_U_COEFFS:  return c.tile_u_coeffs;
            tpts_pkg::REG_TILE_V_COEFFS:  return c.tile_v_coeffs;
            tpts_pkg::REG_TILE_UV_ORIGIN: return c.tile_uv_origin;
            tpts_pkg::REG_STEP_ACROSS:    return c.step_across;
            tpts_pkg::REG_STEP_DOWN:      return c.step_down;
            tpts_pkg::REG_SOURCE_ORIGIN:  return c.source_origin;
            tpts_pkg::REG_SOURCE_WIDTH:   return {{(CFG_W - DIM_W){1'b0}}, c.source_width};
            default:                      return {{(CFG_W - DIM_W){1'b0}}, c.source_height};
        endcase
    endfunction

    // Write every register, one per clock; only called while the block is idle
    task automatic program_regs(input t_cfg c);
        t_cfg_reg r;
        r = r.first();
        repeat (r.num()) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= r;
            i_cfg_data  <= reg_value(c, r);
            @(posedge i_clk);
            sb.write_reg(r, reg_value(c, r));
            r = r.next();
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one item, with an optional random gap first, and hold it until transfer
    task automatic send_item(input t_opcode op, input logic [PIX_W-1:0] px,
                             input logic [PIX_W-1:0] py, input logic [TEX_IDX_W-1:0] col,
                             input logic [TEX_IDX_W-1:0] row, input logic [RGBA_W-1:0] rgba);
        while (!calm && $urandom_range(99) < 7) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_opcode     <= op;
        i_pixel_x    <= px;
        i_pixel_y    <= py;
        i_texel_col  <= col;
        i_texel_row  <= row;
        i_texel_rgba <= rgba;
        do @(posedge i_clk); while (full);
        sb.note_item(op, px, py, col, row, rgba);
        sent++;
    endtask

    // Sample a pixel; fill its texel first when it would land on a blank entry
    task automatic send_sample(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int addr;
        if (sb.hits_blank(px, py, addr))
            send_item(tpts_pkg::OP_LOAD, PIX_W'($urandom), PIX_W'($urandom),
                      TEX_IDX_W'(addr % TILE_W), TEX_IDX_W'(addr / TILE_W), $urandom);
        send_item(tpts_pkg::OP_SAMPLE, px, py, TEX_IDX_W'($urandom), TEX_IDX_W'($urandom),
                  $urandom);
    endtask

    // Load a random texel, mostly inside the active pattern
    task automatic load_random(input t_cfg c);
        int wd, ht;
        logic [TEX_IDX_W-1:0] col, row;
        wd = (c.source_width > TILE_W) ? TILE_W : c.source_width;
        ht = (c.source_height > TILE_H) ? TILE_H : c.source_height;
        if (wd == 0 || ht == 0 || $urandom_range(3) == 0) begin
            col = TEX_IDX_W'($urandom);
            row = TEX_IDX_W'($urandom);
        end else begin
            col = TEX_IDX_W'($urandom_range(wd - 1));
            row = TEX_IDX_W'($urandom_range(ht - 1));
        end
        send_item(tpts_pkg::OP_LOAD, PIX_W'($urandom), PIX_W'($urandom), col, row, $urandom);
    endtask

    // Drop push and wait until every expected pixel has been popped
    task automatic settle();
        push <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_cfg c;
        int   start;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_opcode     <= tpts_pkg::OP_LOAD;
        i_pixel_x    <= '0;
        i_pixel_y    <= '0;
        i_texel_col  <= '0;
        i_texel_row  <= '0;
        i_texel_rgba <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= tpts_pkg::REG_TILE_U_COEFFS;
        i_cfg_data   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: store corners, every sample falls outside an empty pattern
        send_item(tpts_pkg::OP_LOAD, '0, '0, '0, '0, 32'h0000_0000);
        send_item(tpts_pkg::OP_LOAD, '1, '1, '1, '1, 32'hFFFF_FFFF);
        send_item(tpts_pkg::OP_LOAD, '0, '1, '1, '0, 32'hA5A5_5A5A);
        send_item(tpts_pkg::OP_LOAD, '1, '0, '0, '1, 32'h5A5A_A5A5);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        settle();

        // 128-pixel tiles shifted half a texel left over an oversized pattern,
        // so tile-edge pixels land at -0.5 and truncate back to column zero
        c                = '0;
        c.tile_u_coeffs  = pack_fix(ONE / 128, 0);
        c.tile_v_coeffs  = pack_fix(0, ONE / 128);
        c.step_across    = pack_fix(128 * ONE, 0);
        c.step_down      = pack_fix(0, 128 * ONE);
        c.source_origin  = pack_fix(-ONE / 2, 0);
        c.source_width   = 8'd255;
        c.source_height  = 8'd255;
        program_regs(c);
        send_sample(12'd0, 12'd0);
        send_sample(12'd128, 12'd0);
        send_sample(12'd127, 12'd127);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd4095, 12'd0);
        settle();

        // Steep coefficients drive both tile indices into saturation at large pixel coordinates
        c.tile_u_coeffs  = {2{32'h7FFF_FFFF}};
        c.tile_v_coeffs  = {2{32'h8000_0000}};
        c.tile_uv_origin = '0;
        c.step_across    = pack_fix(1, 1);
        c.step_down      = pack_fix(1, 1);
        c.source_origin  = '0;
        c.source_width   = 8'd128;
        c.source_height  = 8'd128;
        program_regs(c);
        send_sample(12'd0, 12'd0);
        send_sample(12'd1, 12'd0);
        send_sample(12'd0, 12'd4095);
        send_sample(12'd4095, 12'd4095);
        settle();

        // Random phases, each under fresh settings and ending with a full drain
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            calm = (ph == 2);
            case (ph % 8)
                3:       c = make_noise();
                7:       c = make_extreme();
                default: c = make_tiled();
            endcase
            program_regs(c);
            start = sent;
            while (sent - start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 30) load_random(c);
                else send_sample(PIX_W'($urandom), PIX_W'($urandom));
            end
            settle();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tpts_pkg.sv
rtl/tpts_ram.sv
rtl/tpts_front.sv
rtl/tpts_back.sv
rtl/tpts_outq.sv
rtl/tiled_pattern_texel_sampler.sv
rtl/tpts_checker.sv
sim/tb_top.sv
